// ----- rtl/tcc_pkg.sv -----
// shared types and constants of the tile constraint collapse core
package tcc_pkg;

   localparam int ROW_W    = 4;
   localparam int COL_W    = 4;
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int CELLS    = 1 << ADDR_W;
   localparam int NUM_ROWS = 1 << ROW_W;
   localparam int NUM_COLS = 1 << COL_W;
   localparam int TILES    = 8;
   localparam int TILE_W   = 3;
   localparam int TERM_W   = 16;
   localparam int ENT_W    = TERM_W + TILE_W;
   localparam int SIDES    = 4;
   localparam int SIDE_W   = 2;
   localparam int CNT_W    = ADDR_W + 1;
   localparam int RAND_W   = 31;
   localparam int DIM_W    = 5;
   localparam int NT_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES = 2'd2;

   localparam logic [SIDE_W-1:0] SIDE_ABOVE = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd1;
   localparam logic [SIDE_W-1:0] SIDE_BELOW = 2'd2;
   localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd3;

   typedef enum logic [2:0] {
      OP_LOAD_ADJ  = 3'd0,
      OP_LOAD_TERM = 3'd1,
      OP_CLEAR     = 3'd2,
      OP_STEP      = 3'd3,
      OP_READ      = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_SCAN1, S_DRAIN1, S_CHECK, S_DIVC, S_SCAN2, S_DRAIN2,
      S_TSTART, S_DIVT, S_FIX, S_NB_RD, S_NB_WR, S_RD, S_RESP
   } state_type;

   typedef struct packed {
      logic              fixed;
      logic [TILE_W-1:0] tile;
      logic [TILES-1:0]  mask;
      logic [ENT_W-1:0]  ent;
   } cell_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [TILE_W-1:0] tile_index;
      logic [SIDE_W-1:0] side;
      logic [TILES-1:0]  allowed_mask;
      logic [TERM_W-1:0] entropy_term;
      logic [ROW_W-1:0]  row_sel;
      logic [COL_W-1:0]  col_sel;
      logic [RAND_W-1:0] rand_cell;
      logic [RAND_W-1:0] rand_tile;
   } req_type;

   typedef struct packed {
      logic              finished;
      logic [ROW_W-1:0]  cell_row;
      logic [COL_W-1:0]  cell_col;
      logic [TILE_W-1:0] cell_tile;
      logic              is_collapsed;
      logic [TILES-1:0]  possible_mask;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic scan_reset;
      logic scan_issue;
      logic scan_pass2;
      logic clear_write;
      logic div_start;
      logic div_tile;
      logic take_pick;
      logic take_tsel;
      logic fix_write;
      logic nb_read;
      logic nb_write;
      logic cell_read;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic clear_last;
      logic found;
      logic div_done;
      logic nb_last;
      logic rsp_free;
   } sts_type;

endpackage

// ----- rtl/tcc_if.sv -----
// request and response channel interfaces
interface tcc_req_if;
   import tcc_pkg::*;
   logic              valid;
   logic              ready;
   logic [2:0]        op;
   logic [TILE_W-1:0] tile_index;
   logic [SIDE_W-1:0] side;
   logic [TILES-1:0]  allowed_mask;
   logic [TERM_W-1:0] entropy_term;
   logic [ROW_W-1:0]  row_sel;
   logic [COL_W-1:0]  col_sel;
   logic [RAND_W-1:0] rand_cell;
   logic [RAND_W-1:0] rand_tile;
   modport source (output valid, op, tile_index, side, allowed_mask, entropy_term,
                   row_sel, col_sel, rand_cell, rand_tile, input ready);
   modport sink (input valid, op, tile_index, side, allowed_mask, entropy_term,
                 row_sel, col_sel, rand_cell, rand_tile, output ready);
endinterface

interface tcc_rsp_if;
   import tcc_pkg::*;
   logic              valid;
   logic              ready;
   logic              finished;
   logic [ROW_W-1:0]  cell_row;
   logic [COL_W-1:0]  cell_col;
   logic [TILE_W-1:0] cell_tile;
   logic              is_collapsed;
   logic [TILES-1:0]  possible_mask;
   modport source (output valid, finished, cell_row, cell_col, cell_tile, is_collapsed,
                   possible_mask, input ready);
   modport sink (input valid, finished, cell_row, cell_col, cell_tile, is_collapsed,
                 possible_mask, output ready);
endinterface

// ----- rtl/tcc_ram.sv -----
// generic single write port ram with registered read
module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/tcc_mod.sv -----
// bit serial remainder unit, one dividend bit per cycle
module tcc_mod import tcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAND_W-1:0] dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [CNT_W-1:0]  remainder
);
   localparam int BIT_W = $clog2(RAND_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [RAND_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      trial   = {rem_ff, dvd_ff[bit_ff]};
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = BIT_W'(RAND_W - 1);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = CNT_W'(trial);
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/tcc_datapath.sv -----
// cell store, tables, scan logic and response register
module tcc_datapath import tcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  req_type              req,
   input  cmd_type              cmd,
   output sts_type              sts,
   output rsp_type              rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready
);
   logic [DIM_W-1:0]  rows_ff, cols_ff;
   logic [NT_W-1:0]   tiles_ff;
   logic [DIM_W-1:0]  nr, nc;
   logic [NT_W-1:0]   nt;
   logic [TILES-1:0]  adj_ff  [TILES*SIDES];
   logic [TERM_W-1:0] term_ff [TILES];
   req_type           item_ff;

   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [SIDE_W-1:0] nb_ff;
   logic              rd_vld_ff, rd_pass2_ff;
   logic [ROW_W-1:0]  rd_row_ff;
   logic [COL_W-1:0]  rd_col_ff;

   logic              found_ff;
   logic [ENT_W-1:0]  best_ff;
   logic [CNT_W-1:0]  ties_ff, seen_ff, pick_ff;
   logic [ROW_W-1:0]  pr_ff;
   logic [COL_W-1:0]  pc_ff;
   logic [TILES-1:0]  mask_ff;
   logic [TILE_W-1:0] tsel_ff, tile_ff;

   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic              row_last, col_last;
   logic [TILES-1:0]  full_mask;
   logic [3:0]        pop;
   logic [TILE_W-1:0] tile_pick;
   logic              nb_ok;
   logic [ROW_W-1:0]  nb_row;
   logic [COL_W-1:0]  nb_col;
   logic [TILES-1:0]  nb_mask;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   cell_type          ram_wdata, ram_rdata;

   logic              div_done;
   logic [CNT_W-1:0]  div_rem, div_dvs;
   logic [RAND_W-1:0] div_dvd;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
      if (v == '0) return DIM_W'(1);
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [ENT_W-1:0] mask_entropy(input logic [TILES-1:0] m);
      logic [ENT_W-1:0] s;
      s = '0;
      for (int t = 0; t < TILES; t++) begin
         if (m[t]) s = s + ENT_W'(term_ff[t]);
      end
      return s;
   endfunction

   assign nr = clamp_dim(rows_ff, DIM_W'(NUM_ROWS));
   assign nc = clamp_dim(cols_ff, DIM_W'(NUM_COLS));
   assign nt = (tiles_ff == '0) ? NT_W'(1) :
               (tiles_ff > NT_W'(TILES)) ? NT_W'(TILES) : tiles_ff;
   assign full_mask = TILES'((9'd1 << nt) - 9'd1);

   assign row_last = ({1'b0, row_ff} == nr - 1'b1);
   assign col_last = ({1'b0, col_ff} == nc - 1'b1);

   // tile choice among the set bits of the picked cell
   always_comb begin
      logic [3:0] seen;
      seen      = '0;
      pop       = '0;
      tile_pick = '0;
      for (int t = 0; t < TILES; t++) begin
         if (mask_ff[t]) begin
            if (seen == {1'b0, tsel_ff}) tile_pick = TILE_W'(t);
            seen = seen + 1'b1;
            pop  = pop + 1'b1;
         end
      end
   end

   always_comb begin
      nb_row = pr_ff;
      nb_col = pc_ff;
      nb_ok  = 1'b0;
      case (nb_ff)
         SIDE_ABOVE: begin
            nb_ok  = (pr_ff != '0);
            nb_row = pr_ff - 1'b1;
         end
         SIDE_RIGHT: begin
            nb_ok  = ({1'b0, pc_ff} + 1'b1 < nc);
            nb_col = pc_ff + 1'b1;
         end
         SIDE_BELOW: begin
            nb_ok  = ({1'b0, pr_ff} + 1'b1 < nr);
            nb_row = pr_ff + 1'b1;
         end
         default: begin
            nb_ok  = (pc_ff != '0);
            nb_col = pc_ff - 1'b1;
         end
      endcase
      nb_mask = ram_rdata.mask & adj_ff[{tile_ff, nb_ff}];
   end

   always_comb begin
      ram_re    = cmd.scan_issue | cmd.nb_read | cmd.cell_read;
      ram_raddr = {row_ff, col_ff};
      if (cmd.nb_read) ram_raddr = {nb_row, nb_col};
      else if (cmd.cell_read) ram_raddr = {item_ff.row_sel, item_ff.col_sel};
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '{fixed: 1'b0, tile: '0, mask: full_mask, ent: mask_entropy(full_mask)};
      if (cmd.clear_write) begin
         ram_we = 1'b1;
      end else if (cmd.fix_write) begin
         ram_we    = 1'b1;
         ram_waddr = {pr_ff, pc_ff};
         ram_wdata = '{fixed: 1'b1, tile: tile_pick, mask: '0, ent: '0};
      end else if (cmd.nb_write) begin
         ram_we    = nb_ok & ~ram_rdata.fixed;
         ram_waddr = {nb_row, nb_col};
         ram_wdata = '{fixed: 1'b0, tile: ram_rdata.tile, mask: nb_mask,
                       ent: mask_entropy(nb_mask)};
      end
   end

   tcc_ram #(.WIDTH($bits(cell_type)), .DEPTH(CELLS)) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign div_dvd = cmd.div_tile ? item_ff.rand_tile : item_ff.rand_cell;
   assign div_dvs = cmd.div_tile ? ((pop == '0) ? CNT_W'(1) : CNT_W'(pop)) : ties_ff;

   tcc_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_W'(4);
         cols_ff      <= DIM_W'(4);
         tiles_ff     <= NT_W'(3);
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS:  rows_ff  <= csr_wdata;
               CSR_COLS:  cols_ff  <= csr_wdata;
               CSR_TILES: tiles_ff <= NT_W'(csr_wdata);
               default:   ;
            endcase
         end
         rd_vld_ff <= cmd.scan_issue;
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (rd_vld_ff && !rd_pass2_ff && ram_rdata.ent != '0 &&
                      (!found_ff || ram_rdata.ent < best_ff)) begin
            found_ff <= 1'b1;
         end
      end

      if (cmd.capture) begin
         item_ff <= req;
         ties_ff <= '0;
         if (req.op == OP_LOAD_ADJ) adj_ff[{req.tile_index, req.side}] <= req.allowed_mask;
         if (req.op == OP_LOAD_TERM) term_ff[req.tile_index] <= req.entropy_term;
      end

      rd_pass2_ff <= cmd.scan_pass2;
      rd_row_ff   <= row_ff;
      rd_col_ff   <= col_ff;

      if (cmd.scan_reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         clr_ff  <= '0;
         nb_ff   <= '0;
         seen_ff <= '0;
      end else begin
         if (cmd.scan_issue) begin
            if (col_last) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (cmd.clear_write) clr_ff <= clr_ff + 1'b1;
         if (cmd.nb_write) nb_ff <= nb_ff + 1'b1;
         if (rd_vld_ff && rd_pass2_ff && ram_rdata.ent == best_ff) begin
            if (seen_ff == pick_ff) begin
               pr_ff   <= rd_row_ff;
               pc_ff   <= rd_col_ff;
               mask_ff <= ram_rdata.mask;
            end
            seen_ff <= seen_ff + 1'b1;
         end
      end

      // first pass keeps the least nonzero entropy and how many cells share it
      if (rd_vld_ff && !rd_pass2_ff && !cmd.capture) begin
         if (ram_rdata.ent != '0 && (!found_ff || ram_rdata.ent < best_ff)) begin
            best_ff <= ram_rdata.ent;
            ties_ff <= CNT_W'(1);
         end else if (found_ff && ram_rdata.ent == best_ff) begin
            ties_ff <= ties_ff + 1'b1;
         end
      end

      if (cmd.take_pick) pick_ff <= div_rem;
      if (cmd.take_tsel) tsel_ff <= TILE_W'(div_rem);
      if (cmd.fix_write) tile_ff <= tile_pick;

      if (cmd.rsp_load) begin
         if (item_ff.op == OP_READ) begin
            rsp_ff <= '{finished: 1'b0, cell_row: item_ff.row_sel, cell_col: item_ff.col_sel,
                        cell_tile: ram_rdata.fixed ? ram_rdata.tile : '0,
                        is_collapsed: ram_rdata.fixed,
                        possible_mask: ram_rdata.fixed ? '0 : ram_rdata.mask};
         end else if (!found_ff) begin
            rsp_ff <= '{finished: 1'b1, default: '0};
         end else begin
            rsp_ff <= '{finished: 1'b0, cell_row: pr_ff, cell_col: pc_ff, cell_tile: tile_ff,
                        is_collapsed: 1'b1, possible_mask: '0};
         end
      end
   end

   assign sts.scan_last  = row_last & col_last;
   assign sts.clear_last = (clr_ff == ADDR_W'(CELLS - 1));
   assign sts.found      = found_ff;
   assign sts.div_done   = div_done;
   assign sts.nb_last    = (nb_ff == SIDE_LEFT);
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_ready;

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.take_pick |=> pick_ff < ties_ff)
      else $error("picked tie index not below tie count");
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_ff != '0 && ties_ff != '0)
      else $error("found minimum without entropy or ties");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("waiting response changed or dropped");
endmodule

// ----- rtl/tcc_ctrl.sv -----
// sequencer for load, clear, step and read operations
module tcc_ctrl import tcc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [2:0] req_op,
   output logic       req_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_STEP:  state_in = S_SCAN1;
                  OP_READ:  state_in = S_RD;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR:  if (sts.clear_last) state_in = S_IDLE;
         S_SCAN1:  if (sts.scan_last) state_in = S_DRAIN1;
         // last read of the first pass lands at the end of the drain cycle
         S_DRAIN1: state_in = S_CHECK;
         S_CHECK:  state_in = sts.found ? S_DIVC : S_RESP;
         S_DIVC:   if (sts.div_done) state_in = S_SCAN2;
         S_SCAN2:  if (sts.scan_last) state_in = S_DRAIN2;
         S_DRAIN2: state_in = S_TSTART;
         S_TSTART: state_in = S_DIVT;
         S_DIVT:   if (sts.div_done) state_in = S_FIX;
         S_FIX:    state_in = S_NB_RD;
         S_NB_RD:  state_in = S_NB_WR;
         S_NB_WR:  state_in = sts.nb_last ? S_RESP : S_NB_RD;
         S_RD:     state_in = S_RESP;
         S_RESP:   if (sts.rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture    = accept;
            cmd.scan_reset = accept;
         end
         S_CLEAR:  cmd.clear_write = 1'b1;
         S_SCAN1:  cmd.scan_issue  = 1'b1;
         S_DRAIN1: cmd = '0;
         S_CHECK:  cmd.div_start   = sts.found;
         S_DIVC: begin
            cmd.take_pick  = sts.div_done;
            cmd.scan_reset = sts.div_done;
         end
         S_SCAN2: begin
            cmd.scan_issue = 1'b1;
            cmd.scan_pass2 = 1'b1;
         end
         S_DRAIN2: cmd.scan_pass2 = 1'b1;
         S_TSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_tile  = 1'b1;
         end
         S_DIVT:   cmd.take_tsel = sts.div_done;
         S_FIX:    cmd.fix_write = 1'b1;
         S_NB_RD:  cmd.nb_read   = 1'b1;
         S_NB_WR:  cmd.nb_write  = 1'b1;
         S_RD:     cmd.cell_read = 1'b1;
         S_RESP:   cmd.rsp_load  = sts.rsp_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.rsp_free)
      else $error("response loaded over an untaken transfer");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN2 |-> sts.found)
      else $error("second pass without a minimum");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVT && sts.div_done) |=> state_ff == S_FIX)
      else $error("tile choice not followed by fix");
endmodule

// ----- rtl/tile_constraint_collapse_core.sv -----
// Top level: one op per transfer.
// Clear sweeps all 256 cells of the one-write-port cell RAM.
// Step: two passes of R*C RAM reads, two remainder runs and a
// read-modify-write of each of the four neighbor cells.
// Reset is synchronous and clears control; cells and tables stay undefined
// until the tables are loaded and a clear has run.
module tile_constraint_collapse_core import tcc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tcc_req_if.sink              req_if,
   tcc_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);
   req_type req;
   rsp_type rsp;
   cmd_type cmd;
   sts_type sts;
   logic    ready;

   assign req = '{op: req_if.op, tile_index: req_if.tile_index, side: req_if.side,
                  allowed_mask: req_if.allowed_mask, entropy_term: req_if.entropy_term,
                  row_sel: req_if.row_sel, col_sel: req_if.col_sel,
                  rand_cell: req_if.rand_cell, rand_tile: req_if.rand_tile};
   assign req_if.ready = ready;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_op    (req_if.op),
      .req_ready (ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready)
   );

   assign rsp_if.finished      = rsp.finished;
   assign rsp_if.cell_row      = rsp.cell_row;
   assign rsp_if.cell_col      = rsp.cell_col;
   assign rsp_if.cell_tile     = rsp.cell_tile;
   assign rsp_if.is_collapsed  = rsp.is_collapsed;
   assign rsp_if.possible_mask = rsp.possible_mask;
endmodule

// ----- sim/tile_constraint_collapse_core_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the tile constraint collapse core
module tile_constraint_collapse_core_tb;
   import tcc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [2:0] OP_UNUSED_5 = 3'd5;
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;
   localparam int SETTLE_CYCLES  = 2 * CELLS + 200;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASES         = 8;
   localparam int GAME_ITEMS     = 34;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_wdata = '0;

   tcc_req_if req_if();
   tcc_rsp_if rsp_if();

   tile_constraint_collapse_core DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // grid and table image kept in step with the block
   logic [DIM_W-1:0]  rows_cfg  = 5'd4;
   logic [DIM_W-1:0]  cols_cfg  = 5'd4;
   logic [NT_W-1:0]   tiles_cfg = 4'd3;
   logic [TILE_W-1:0] grid_tile [CELLS];
   bit                grid_fixed [CELLS];
   logic [TILES-1:0]  grid_mask [CELLS];
   logic [ENT_W-1:0]  grid_ent [CELLS];
   logic [TILES-1:0]  adj_rules [TILES*SIDES];
   logic [TERM_W-1:0] tile_terms [TILES];

   rsp_type pending_cells[$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic int clamp_dim(int v, int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [ENT_W-1:0] mask_entropy_sum(logic [TILES-1:0] m);
      logic [ENT_W-1:0] s;
      s = '0;
      for (int t = 0; t < TILES; t++) if (m[t]) s += ENT_W'(tile_terms[t]);
      return s;
   endfunction

   function automatic void narrow_cell(int r, int c, logic [TILES-1:0] allowed);
      int k;
      k = r * NUM_COLS + c;
      if (!grid_fixed[k]) begin
         grid_mask[k] &= allowed;
         grid_ent[k] = mask_entropy_sum(grid_mask[k]);
      end
   endfunction

   // applies one request to the grid image; returns 1 when a response is due
   function automatic bit collapse_predict(input req_type q, output rsp_type o);
      int nr, nc, nt, k, pr, pc, cnt, tile;
      int unsigned ties, pick, seen, tsel;
      logic [ENT_W-1:0] best, e;
      logic [TILES-1:0] full, m;
      bit found;
      o = '0;
      nr = clamp_dim(rows_cfg, NUM_ROWS);
      nc = clamp_dim(cols_cfg, NUM_COLS);
      case (q.op)
         OP_LOAD_ADJ: begin
            adj_rules[q.tile_index * SIDES + q.side] = q.allowed_mask;
            return 0;
         end
         OP_LOAD_TERM: begin
            tile_terms[q.tile_index] = q.entropy_term;
            return 0;
         end
         OP_CLEAR: begin
            nt = clamp_dim(tiles_cfg, TILES);
            full = TILES'((1 << nt) - 1);
            e = mask_entropy_sum(full);
            for (int i = 0; i < CELLS; i++) begin
               grid_tile[i] = '0;
               grid_fixed[i] = 0;
               grid_mask[i] = full;
               grid_ent[i] = e;
            end
            return 0;
         end
         OP_STEP: begin
            found = 0;
            best = '0;
            for (int r = 0; r < nr; r++)
               for (int c = 0; c < nc; c++) begin
                  e = grid_ent[r * NUM_COLS + c];
                  if (e != 0 && (!found || e < best)) begin
                     best = e;
                     found = 1;
                  end
               end
            if (!found) begin
               o.finished = 1'b1;
               return 1;
            end
            ties = 0;
            for (int r = 0; r < nr; r++)
               for (int c = 0; c < nc; c++)
                  if (grid_ent[r * NUM_COLS + c] == best) ties++;
            pick = q.rand_cell % ties;
            seen = 0;
            pr = 0;
            pc = 0;
            for (int r = 0; r < nr; r++)
               for (int c = 0; c < nc; c++)
                  if (grid_ent[r * NUM_COLS + c] == best) begin
                     if (seen == pick) begin
                        pr = r;
                        pc = c;
                     end
                     seen++;
                  end
            k = pr * NUM_COLS + pc;
            m = grid_mask[k];
            cnt = $countones(m);
            if (cnt == 0) cnt = 1;
            tsel = q.rand_tile % cnt;
            seen = 0;
            tile = 0;
            for (int t = 0; t < TILES; t++)
               if (m[t]) begin
                  if (seen == tsel) tile = t;
                  seen++;
               end
            grid_tile[k] = TILE_W'(tile);
            grid_fixed[k] = 1;
            grid_mask[k] = '0;
            grid_ent[k] = '0;
            if (pr > 0) narrow_cell(pr - 1, pc, adj_rules[tile * SIDES + SIDE_ABOVE]);
            if (pc + 1 < nc) narrow_cell(pr, pc + 1, adj_rules[tile * SIDES + SIDE_RIGHT]);
            if (pr + 1 < nr) narrow_cell(pr + 1, pc, adj_rules[tile * SIDES + SIDE_BELOW]);
            if (pc > 0) narrow_cell(pr, pc - 1, adj_rules[tile * SIDES + SIDE_LEFT]);
            o.cell_row = ROW_W'(pr);
            o.cell_col = COL_W'(pc);
            o.cell_tile = TILE_W'(tile);
            o.is_collapsed = 1'b1;
            return 1;
         end
         OP_READ: begin
            k = q.row_sel * NUM_COLS + q.col_sel;
            o.cell_row = q.row_sel;
            o.cell_col = q.col_sel;
            if (grid_fixed[k]) begin
               o.cell_tile = grid_tile[k];
               o.is_collapsed = 1'b1;
            end else begin
               o.possible_mask = grid_mask[k];
            end
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic req_type make_req(logic [2:0] op, int tile, int side, int mask,
                                        int term, int row, int col, int rc, int rt);
      req_type q;
      q.op = op;
      q.tile_index = TILE_W'(tile);
      q.side = SIDE_W'(side);
      q.allowed_mask = TILES'(mask);
      q.entropy_term = TERM_W'(term);
      q.row_sel = ROW_W'(row);
      q.col_sel = COL_W'(col);
      q.rand_cell = RAND_W'(rc);
      q.rand_tile = RAND_W'(rt);
      return q;
   endfunction

   // random payload, every field drawn over its whole width
   function automatic req_type random_req(logic [2:0] op);
      req_type q;
      q = $bits(req_type)'({$urandom, $urandom, $urandom, $urandom});
      q.op = op;
      return q;
   endfunction

   task automatic send_req(input req_type q, input bit typed, input rsp_type typed_rsp,
                           output bit finished_seen);
      rsp_type p;
      bit has;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= q.op;
      req_if.tile_index <= q.tile_index;
      req_if.side <= q.side;
      req_if.allowed_mask <= q.allowed_mask;
      req_if.entropy_term <= q.entropy_term;
      req_if.row_sel <= q.row_sel;
      req_if.col_sel <= q.col_sel;
      req_if.rand_cell <= q.rand_cell;
      req_if.rand_tile <= q.rand_tile;
      do @(posedge clock); while (!req_if.ready);
      has = collapse_predict(q, p);
      finished_seen = has && p.finished;
      if (has) pending_cells = {pending_cells, (typed ? typed_rsp : p)};
   endtask

   task automatic send_plain(input req_type q);
      bit fin;
      send_req(q, 0, '0, fin);
   endtask

   // wait for every response; optionally let a clear or step still running finish
   task automatic wait_results(input bit settle);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= DIM_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ROWS:  rows_cfg = DIM_W'(val);
         CSR_COLS:  cols_cfg = DIM_W'(val);
         CSR_TILES: tiles_cfg = NT_W'(val);
         default: ;
      endcase
   endtask

   task automatic load_tables();
      req_type q;
      for (int t = 0; t < TILES; t++) begin
         q = random_req(OP_LOAD_TERM);
         q.tile_index = TILE_W'(t);
         case ($urandom_range(9))
            0: q.entropy_term = '0;
            1: q.entropy_term = '1;
            default: ;
         endcase
         send_plain(q);
      end
      for (int i = 0; i < TILES * SIDES; i++) begin
         q = random_req(OP_LOAD_ADJ);
         q.tile_index = TILE_W'(i / SIDES);
         q.side = SIDE_W'(i % SIDES);
         // mostly permissive rules so that games run long
         if ($urandom_range(9) < 7) q.allowed_mask = TILES'($urandom | $urandom);
         send_plain(q);
      end
   endtask

   always @(negedge clock) rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin : check_and_watch
      rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_cells.size() == 0) begin
               $error("response transfer with nothing expected");
               errors++;
            end else begin
               want = pending_cells.pop_front();
               if (rsp_if.finished !== want.finished) begin
                  $error("finished: expected %0d, got %0d", want.finished, rsp_if.finished);
                  errors++;
               end
               if (rsp_if.cell_row !== want.cell_row) begin
                  $error("cell_row: expected %0d, got %0d", want.cell_row, rsp_if.cell_row);
                  errors++;
               end
               if (rsp_if.cell_col !== want.cell_col) begin
                  $error("cell_col: expected %0d, got %0d", want.cell_col, rsp_if.cell_col);
                  errors++;
               end
               if (rsp_if.cell_tile !== want.cell_tile) begin
                  $error("cell_tile: expected %0d, got %0d", want.cell_tile, rsp_if.cell_tile);
                  errors++;
               end
               if (rsp_if.is_collapsed !== want.is_collapsed) begin
                  $error("is_collapsed: expected %0d, got %0d", want.is_collapsed,
                         rsp_if.is_collapsed);
                  errors++;
               end
               if (rsp_if.possible_mask !== want.possible_mask) begin
                  $error("possible_mask: expected %h, got %h", want.possible_mask,
                         rsp_if.possible_mask);
                  errors++;
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tile_constraint_collapse_core verification failed");
            $finish;
         end
      end
   end

   int set_rows [PHASES] = '{4, 1, 0, 16, 31, 2, 3, 6};
   int set_cols [PHASES] = '{4, 1, 0, 16, 31, 5, 2, 3};
   int set_tiles [PHASES] = '{3, 1, 0, 8, 15, 4, 2, 5};

   initial begin
      dir_row_type dir_rows[$];
      dir_row_type row;
      req_type q;
      bit fin, last_fin;
      int nr, nc, roll, game_count;

      req_if.valid = 1'b0;
      req_if.op = '0;
      req_if.tile_index = '0;
      req_if.side = '0;
      req_if.allowed_mask = '0;
      req_if.entropy_term = '0;
      req_if.row_sel = '0;
      req_if.col_sel = '0;
      req_if.rand_cell = '0;
      req_if.rand_tile = '0;
      rsp_if.ready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // terms the directed part does not set get random values; all rules start permissive
      for (int t = 3; t < TILES; t++) send_plain(make_req(OP_LOAD_TERM, t, 0, 0, $urandom,
                                                          0, 0, 0, 0));
      for (int i = 0; i < TILES * SIDES; i++)
         send_plain(make_req(OP_LOAD_ADJ, i / SIDES, i % SIDES, 8'hFF, 0, 0, 0, 0, 0));

      // reset grid size is 4 x 4 with three tiles; all cells tie at the first step
      dir_rows = '{
         '{make_req(OP_LOAD_TERM, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_LOAD_TERM, 1, 0, 0, 16'h0000, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_LOAD_TERM, 2, 0, 0, 16'h0001, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_LOAD_ADJ, 0, SIDE_RIGHT, 8'h00, 0, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_LOAD_ADJ, 7, SIDE_LEFT, 8'hFF, 0, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, rsp_type'({1'b0, 4'd0, 4'd0, 3'd0,
                                                                  1'b0, 8'h07})},
         '{make_req(OP_READ, 0, 0, 0, 0, 15, 15, 0, 0), 1,
           rsp_type'({1'b0, 4'd15, 4'd15, 3'd0, 1'b0, 8'h07})},
         '{make_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 1, rsp_type'({1'b0, 4'd0, 4'd0, 3'd0,
                                                                  1'b1, 8'h00})},
         '{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, rsp_type'({1'b0, 4'd0, 4'd0, 3'd0,
                                                                  1'b1, 8'h00})},
         // right neighbor emptied by the zero rule
         '{make_req(OP_READ, 0, 0, 0, 0, 0, 1, 0, 0), 1, rsp_type'({1'b0, 4'd0, 4'd1, 3'd0,
                                                                  1'b0, 8'h00})},
         '{make_req(OP_UNUSED_5, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_UNUSED_6, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_UNUSED_7, 7, 3, 8'hFF, 16'hFFFF, 15, 15, 0, 0), 0, '0},
         '{make_req(OP_STEP, 7, 3, 8'hFF, 16'hFFFF, 15, 15, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, '0},
         '{make_req(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0},
         '{make_req(OP_READ, 0, 0, 0, 0, 3, 3, 0, 0), 0, '0},
         '{make_req(OP_READ, 0, 0, 0, 0, 0, 1, 0, 0), 0, '0}
      };
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_req(row.req, row.typed, row.rsp, fin);
      end

      for (int p = 0; p < PHASES; p++) begin
         wait_results(1);
         if (p == 0) write_csr(CSR_SPARE, 5'h1F);
         write_csr(CSR_ROWS, set_rows[p]);
         write_csr(CSR_COLS, set_cols[p]);
         write_csr(CSR_TILES, set_tiles[p]);
         send_idle_pct  = (p % 4 == 1) ? 58 : ((p % 4 == 3) ? 26 : 0);
         recv_stall_pct = (p % 4 == 2) ? 58 : ((p % 4 == 3) ? 26 : 0);
         nr = clamp_dim(rows_cfg, NUM_ROWS);
         nc = clamp_dim(cols_cfg, NUM_COLS);
         load_tables();
         send_plain(random_req(OP_CLEAR));
         last_fin = 0;
         game_count = 0;
         while (game_count < GAME_ITEMS) begin
            if (game_count == GAME_ITEMS / 2) wait_results(0);
            roll = $urandom_range(99);
            if (last_fin && roll < 50) begin
               q = random_req(OP_CLEAR);
            end else if (roll < 60) begin
               q = random_req(OP_STEP);
            end else if (roll < 85) begin
               q = random_req(OP_READ);
               if ($urandom_range(9) < 8) begin
                  q.row_sel = ROW_W'($urandom_range(nr - 1));
                  q.col_sel = COL_W'($urandom_range(nc - 1));
               end
            end else if (roll < 91) begin
               q = random_req(($urandom_range(1) != 0) ? OP_LOAD_ADJ : OP_LOAD_TERM);
            end else if (roll < 94) begin
               q = random_req(OP_CLEAR);
            end else begin
               q = random_req(3'($urandom_range(OP_UNUSED_7, OP_UNUSED_5)));
               game_count--;
            end
            send_req(q, 0, '0, fin);
            if (q.op == OP_STEP) last_fin = fin;
            if (q.op == OP_CLEAR) last_fin = 0;
            game_count++;
         end
      end

      wait_results(1);
      if (errors == 0)
         $display("tile_constraint_collapse_core verification clean");
      else
         $display("tile_constraint_collapse_core verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_ram.sv
rtl/tcc_mod.sv
rtl/tcc_datapath.sv
rtl/tcc_ctrl.sv
rtl/tile_constraint_collapse_core.sv
sim/tile_constraint_collapse_core_tb.sv
